FILE: rtl/plist_pkg.sv
// Package for the positional list block: sizes, field widths, operation and
// status codes, and the result record passed to the output stage.
// No dependencies; the interfaces, sequencer, output register and top level import it.
`default_nettype none

package plist_pkg;

  // Store capacity and the widths derived from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 7;

  // Width used to compare a position against the fill count.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ELEMENT  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

  // One result item as it travels from the sequencer to the output register.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/plist_in_if.sv
// Request channel of the positional list block: valid/ready plus the
// operation, position and value fields. Depends on plist_pkg.
`default_nettype none

interface plist_in_if;
  import plist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/plist_out_if.sv
// Result channel of the positional list block: valid/ready plus status,
// index, element and last. Depends on plist_pkg.
`default_nettype none

interface plist_out_if;
  import plist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [INDEX_W-1:0]       index;
  logic signed [DATA_W-1:0] element;
  logic                     last;

  modport source (output valid, output status, output index, output element, output last,
                  input ready);
  modport sink (input valid, input status, input index, input element, input last,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/plist_ram.sv
// Generic simple dual-port RAM: one write port and one read port with a
// registered read that holds its data while no read is enabled. No dependencies.
`default_nettype none

module plist_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plist_obuf.sv
// Output register of the positional list block: holds one result until the
// result channel takes it. Depends on plist_pkg and plist_out_if.
`default_nettype none

module plist_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  plist_pkg::res_t   res,
  output logic              res_ready,
  plist_out_if.source       rsp
);
  import plist_pkg::*;

  logic valid;
  res_t data;

  // The register can load when it is empty or its result is being transferred.
  assign res_ready = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data <= res;
    end
  end

  assign rsp.valid   = valid;
  assign rsp.status  = data.status;
  assign rsp.index   = data.index;
  assign rsp.element = data.element;
  assign rsp.last    = data.last;

endmodule

`default_nettype wire

FILE: rtl/plist_seq.sv
// Sequencer of the positional list block: decodes a request, produces results and
// walks the entry RAM one entry per cycle unless a result stalls. Depends on plist_pkg.
`default_nettype none

module plist_seq (
  input  logic                          clk,
  input  logic                          rst,
  plist_in_if.sink                      req,
  output logic                          mem_we,
  output logic [plist_pkg::IDX_W-1:0]   mem_waddr,
  output logic [plist_pkg::DATA_W-1:0]  mem_wdata,
  output logic                          mem_re,
  output logic [plist_pkg::IDX_W-1:0]   mem_raddr,
  input  logic [plist_pkg::DATA_W-1:0]  mem_rdata,
  output logic                          res_valid,
  output plist_pkg::res_t               res,
  input  logic                          res_ready
);
  import plist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_REPLY,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t               state;
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     pos0;
  logic [DATA_W-1:0]    val_q;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     ra;
  logic                 rd_more;
  logic                 pend;
  logic [IDX_W-1:0]     pend_addr;
  logic                 hold_valid;
  logic [IDX_W-1:0]     hold_idx;
  logic [STATUS_W-1:0]  reply_status;

  logic                 accept;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     target;
  logic                 is_full;
  logic                 bad_pos;
  logic                 match;
  logic                 need_out;
  logic                 adv;
  logic [CNT_W-1:0]     pend_num;
  logic [CNT_W-1:0]     ra_num;
  logic [IDX_W-1:0]     last_addr;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Request decode: target slot and the invalid and full checks.
  assign pos_ext   = CMP_W'(req.position);
  assign cnt_ext   = CMP_W'(count);
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign bad_pos   = (req.position == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign last_addr = IDX_W'(count - CNT_W'(1));

  always_comb begin
    case (req.op)
      OP_INS_FRONT: target = '0;
      OP_INS_END:   target = cnt_ext;
      default:      target = pos_ext - CMP_W'(1);
    endcase
  end

  // Scan helpers: match test and 1-based numbers of the pending entry and the read address.
  assign match    = (mem_rdata == val_q);
  assign pend_num = CNT_W'(pend_addr) + CNT_W'(1);
  assign ra_num   = CNT_W'(ra) + CNT_W'(1);

  // Result generation and the advance condition of the scan pipeline.
  always_comb begin
    need_out    = 1'b0;
    res         = '0;
    case (state)
      S_REPLY: begin
        need_out    = 1'b1;
        res.status  = reply_status;
        res.last    = 1'b1;
      end
      S_SCAN: begin
        if (pend && (op_q == OP_DISPLAY)) begin
          need_out    = 1'b1;
          res.status  = ST_ELEMENT;
          res.index   = INDEX_W'(pend_num);
          res.element = mem_rdata;
          res.last    = (pend_num == count);
        end else if (pend && match && hold_valid) begin
          // An earlier match is released once a later one shows it is not the last.
          need_out    = 1'b1;
          res.status  = ST_FOUND;
          res.index   = INDEX_W'(CNT_W'(hold_idx) + CNT_W'(1));
        end
      end
      S_FINISH: begin
        need_out = 1'b1;
        res.last = 1'b1;
        if (hold_valid) begin
          res.status = ST_FOUND;
          res.index  = INDEX_W'(CNT_W'(hold_idx) + CNT_W'(1));
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
        need_out = 1'b0;
      end
    endcase
  end

  assign res_valid = need_out;
  assign adv       = !need_out || res_ready;

  // RAM accesses. During a shift the write lands two entries above the read,
  // so the ports never touch the same entry in one cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(CNT_W'(pend_addr) + CNT_W'(1));
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = ra;
    case (state)
      S_SHIFT: begin
        mem_we = pend;
        mem_re = rd_more;
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos0;
        mem_wdata = val_q;
      end
      S_SCAN: begin
        mem_re = rd_more && adv;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_more    <= 1'b0;
      pend       <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.op;
            val_q <= req.value;
            case (req.op)
              OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                pos0 <= IDX_W'(target);
                if ((req.op == OP_INS_POS) && bad_pos) begin
                  reply_status <= ST_INVALID;
                  state        <= S_REPLY;
                end else if (is_full) begin
                  reply_status <= ST_FULL;
                  state        <= S_REPLY;
                end else if (target < cnt_ext) begin
                  ra      <= last_addr;
                  rd_more <= 1'b1;
                  pend    <= 1'b0;
                  state   <= S_SHIFT;
                end else begin
                  state <= S_PLACE;
                end
              end
              OP_SEARCH, OP_DISPLAY: begin
                if (count == '0) begin
                  reply_status <= (req.op == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                  state        <= S_REPLY;
                end else begin
                  ra         <= '0;
                  rd_more    <= 1'b1;
                  pend       <= 1'b0;
                  hold_valid <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SHIFT: begin
          // Walk down from the top entry, moving each one up by one slot.
          if (rd_more) begin
            pend      <= 1'b1;
            pend_addr <= ra;
            ra        <= ra - IDX_W'(1);
            rd_more   <= (ra != pos0);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          count        <= count + CNT_W'(1);
          reply_status <= ST_INSERTED;
          state        <= S_REPLY;
        end
        S_REPLY: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (adv) begin
            if (pend && (op_q == OP_SEARCH) && match) begin
              hold_valid <= 1'b1;
              hold_idx   <= pend_addr;
            end
            if (rd_more) begin
              pend      <= 1'b1;
              pend_addr <= ra;
              ra        <= ra + IDX_W'(1);
              rd_more   <= (ra_num != count);
            end else begin
              pend  <= 1'b0;
              state <= (op_q == OP_DISPLAY) ? S_IDLE : S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/positional_list_insert_search.sv
// Top level of the positional list block: sequencer, entry RAM and output
// register. Depends on plist_pkg, plist_in_if, plist_out_if and the submodules.
`default_nettype none

// Keeps an ordered list of up to CAPACITY signed 32-bit values in one RAM
// with a registered read. One request is processed at a time; req.ready is
// high only while the block is idle. An insert that lands in front of
// stored entries moves every entry from the target position on up one
// slot, one entry per cycle through the RAM read and write ports. Stalls
// on the result channel stretch every request that gives a result. Each
// result leaves through an output register. Each request gives its results
// in order with last set on the final one; unused opcodes are dropped
// without a result. The RAM needs no clearing after reset, since only
// entries below the fill count are ever read.

module positional_list_insert_search (
  input  logic         clk,
  input  logic         rst,
  plist_in_if.sink     req,
  plist_out_if.source  rsp
);
  import plist_pkg::*;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // Request decode and the walk over the stored entries.
  plist_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Entry storage.
  plist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register toward the output channel.
  plist_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
